[sv/cf16_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cf16_pkg
// Shared constants and types of the CRC-16 frame builder.
// ----------------------------------------------------------------------------
package cf16_pkg;

    typedef logic [3:0]  slot_t;
    typedef logic [15:0] crc_t;

    localparam logic [7:0]  START_MARK = 8'h7E;
    localparam crc_t        CRC_INIT   = 16'hFFFF;
    localparam crc_t        CRC_POLY   = 16'hA001;
    localparam logic [15:0] LEN_EXTRA  = 16'd3;

    // positions of the bytes one item can produce
    localparam slot_t SLOT_MARK_A  = 4'd0;
    localparam slot_t SLOT_MARK_B  = 4'd1;
    localparam slot_t SLOT_LEN_HI  = 4'd2;
    localparam slot_t SLOT_LEN_LO  = 4'd3;
    localparam slot_t SLOT_CMD     = 4'd4;
    localparam slot_t SLOT_SEQ_HI  = 4'd5;
    localparam slot_t SLOT_SEQ_LO  = 4'd6;
    localparam slot_t SLOT_DATA    = 4'd7;
    localparam slot_t SLOT_CRC_LO  = 4'd8;
    localparam slot_t SLOT_CRC_HI  = 4'd9;

endpackage

`default_nettype wire

[sv/cf16_crc_byte.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cf16_crc_byte
// One-byte update of a reflected CRC-16/MODBUS remainder.
// ----------------------------------------------------------------------------
module cf16_crc_byte (
    input  wire cf16_pkg::crc_t crc_in,
    input  wire logic [7:0]     data,
    output cf16_pkg::crc_t      crc_out
);

    always_comb
    begin
        cf16_pkg::crc_t c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ cf16_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

[sv/crc16_frame_builder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_builder_unit
// Streams frames: two start marks, length, command, sequence number, payload
// and a CRC-16/MODBUS trailer, one byte per result transfer.
// ----------------------------------------------------------------------------
// items wait in the input register and result bytes in the result register
// throughput: one result byte per cycle unless result_ready stalls it; an item
//   holds the input register until its last result is emitted, so plain payload
//   items stream at one per cycle too, set by the single byte output port
// reset: outside any frame, sequence number 0, running crc 0xFFFF, no item
//   held and no result pending
module crc16_frame_builder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [7:0]  command,
    input  wire logic [15:0] payload_length,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        frame_last,

    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [7:0]       out_byte,
    output logic             end_of_frame,
    output logic             run_last
);

    // input register
    logic        hold_reg;
    logic [7:0]  cmd_reg;
    logic [15:0] plen_reg;
    logic [7:0]  data_reg;
    logic        present_reg;
    logic        last_reg;

    // frame state
    logic [15:0]     seq_reg,    seq_next;
    cf16_pkg::crc_t  crc_reg,    crc_next;
    logic            inside_reg, inside_next;
    cf16_pkg::slot_t pos_reg,    pos_next;

    // result register
    logic        rvalid_reg, rvalid_next;
    logic [7:0]  rbyte_reg;
    logic        reof_reg;
    logic        rlast_reg;

    logic            first;
    logic            close;
    logic            has_out;
    cf16_pkg::slot_t cur;
    logic            cur_last;
    logic [7:0]      cur_byte;
    logic [15:0]     flen;
    logic            out_free;
    logic            go;
    logic            emit;
    logic            done;
    cf16_pkg::crc_t  crc_base;
    cf16_pkg::crc_t  crc_upd;

    assign first   = !inside_reg;
    assign close   = last_reg || (first && !present_reg);
    assign has_out = first || present_reg || close;
    assign flen    = plen_reg + cf16_pkg::LEN_EXTRA;

    // next byte position of the held item at or after pos_reg
    always_comb
    begin
        priority if (first && pos_reg <= cf16_pkg::SLOT_SEQ_LO)
        begin
            cur = pos_reg;
        end
        else if (present_reg && pos_reg <= cf16_pkg::SLOT_DATA)
        begin
            cur = cf16_pkg::SLOT_DATA;
        end
        else if (pos_reg <= cf16_pkg::SLOT_CRC_LO)
        begin
            cur = cf16_pkg::SLOT_CRC_LO;
        end
        else
        begin
            cur = cf16_pkg::SLOT_CRC_HI;
        end
    end

    assign cur_last = (cur == cf16_pkg::SLOT_CRC_HI)
                   || (cur == cf16_pkg::SLOT_DATA && !close);

    always_comb
    begin
        unique case (cur)
            cf16_pkg::SLOT_MARK_A: cur_byte = cf16_pkg::START_MARK;
            cf16_pkg::SLOT_MARK_B: cur_byte = cf16_pkg::START_MARK;
            cf16_pkg::SLOT_LEN_HI: cur_byte = flen[15:8];
            cf16_pkg::SLOT_LEN_LO: cur_byte = flen[7:0];
            cf16_pkg::SLOT_CMD:    cur_byte = cmd_reg;
            cf16_pkg::SLOT_SEQ_HI: cur_byte = seq_reg[15:8];
            cf16_pkg::SLOT_SEQ_LO: cur_byte = seq_reg[7:0];
            cf16_pkg::SLOT_DATA:   cur_byte = data_reg;
            cf16_pkg::SLOT_CRC_LO: cur_byte = crc_reg[7:0];
            default:               cur_byte = crc_reg[15:8];
        endcase
    end

    assign out_free   = !rvalid_reg || result_ready;
    assign go         = hold_reg && (out_free || !has_out);
    assign emit       = go && has_out;
    assign done       = go && (!has_out || cur_last);
    assign item_ready = !hold_reg || done;

    // a new frame restarts the crc at its first start mark
    assign crc_base = (cur == cf16_pkg::SLOT_MARK_A) ? cf16_pkg::CRC_INIT : crc_reg;

    cf16_crc_byte u_crc (
        .crc_in  (crc_base),
        .data    (cur_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        seq_next    = seq_reg;
        crc_next    = crc_reg;
        inside_next = inside_reg;
        pos_next    = pos_reg;
        rvalid_next = rvalid_reg && !result_ready;
        if (emit)
        begin
            rvalid_next = 1'b1;
            pos_next    = cur + cf16_pkg::slot_t'(1);
            if (cur <= cf16_pkg::SLOT_DATA)
            begin
                crc_next = crc_upd;
            end
            else if (cur == cf16_pkg::SLOT_CRC_HI)
            begin
                crc_next = cf16_pkg::CRC_INIT;
            end
        end
        if (done)
        begin
            pos_next    = cf16_pkg::SLOT_MARK_A;
            inside_next = !close;
            if (first)
            begin
                seq_next = seq_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 1'b0;
            seq_reg    <= '0;
            crc_reg    <= cf16_pkg::CRC_INIT;
            inside_reg <= 1'b0;
            pos_reg    <= cf16_pkg::SLOT_MARK_A;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            hold_reg   <= (hold_reg && !done) || item_valid;
            seq_reg    <= seq_next;
            crc_reg    <= crc_next;
            inside_reg <= inside_next;
            pos_reg    <= pos_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            cmd_reg     <= command;
            plen_reg    <= payload_length;
            data_reg    <= data_byte;
            present_reg <= byte_present;
            last_reg    <= frame_last;
        end
        if (emit)
        begin
            rbyte_reg <= cur_byte;
            reof_reg  <= (cur == cf16_pkg::SLOT_CRC_HI);
            rlast_reg <= cur_last;
        end
    end

    assign result_valid = rvalid_reg;
    assign out_byte     = rbyte_reg;
    assign end_of_frame = reof_reg;
    assign run_last     = rlast_reg;

    // the frame trailer always closes the run of its item
    a_eof_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && end_of_frame) |-> run_last)
        else $error("end of frame without run_last");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= cf16_pkg::SLOT_CRC_HI)
        else $error("byte position out of range");

    a_close_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (done && close) |=> !inside_reg)
        else $error("frame still open after crc");

    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cur == cf16_pkg::SLOT_CRC_HI) |=> (crc_reg == cf16_pkg::CRC_INIT))
        else $error("crc not restarted after trailer");

    a_no_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && !result_ready) |=> ($stable(rbyte_reg) && rvalid_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
